### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by deq_cell and double_ended_queue_top; depends on nothing else.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEQ_DEPTH  = 16;
  localparam int DEQ_DATA_W = 32;

  // Command codes carried by an input item
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } deq_cmd_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                         en;
    deq_cmd_t                     cmd;
    logic signed [DEQ_DATA_W-1:0] value;
  } deq_ctl_t;

endpackage

### sv/double_ended_queue_top.sv
// Top level of the double-ended queue: a chain of deq_cell instances and
// the command sequencer with its result register. Depends on deq_pkg.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+-----------
//   input   | in_valid, in_stall, in_cmd, in_value   | to block
//   result  | out_valid, out_stall, out_ok,          | from block
//           | out_popped_value, out_is_empty         |
//
// Push front, push back, pop front and any failed pop register their result
// straight from S_IDLE. A successful pop back holds the block in S_SETTLE:
// the back entry travels one cell per cycle along the forwarding chain until
// it reaches cell 0, and only then is its result registered.
// Entries stay packed at the front of the chain, cell 0 holding the front.
// Reset (synchronous, rst_n low) clears every valid bit: the queue is empty.
// A stalled result holds; a new item is taken while the result is being
// taken, and no item is taken while a pop back is still in progress.
`timescale 1ns / 1ps

module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic signed [DEQ_DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic signed [DEQ_DATA_W-1:0] out_popped_value,
  output logic                         out_is_empty
);

  localparam int CNT_W = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SETTLE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic signed [DEQ_DATA_W-1:0] out_popped_r, out_popped_nxt;
  logic                         out_empty_r, out_empty_nxt;

  deq_ctl_t                     ctl;
  logic [DEPTH-1:0]             valid_w;
  logic signed [DEQ_DATA_W-1:0] data_w [DEPTH];
  logic signed [DEQ_DATA_W-1:0] tail_w [DEPTH];

  logic     slot_free;
  logic     accept;
  logic     full;
  logic     empty;
  deq_cmd_t cmd;

  // Build the chain: cell 0 takes the pushed value from the left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         lv, rv;
    logic signed [DEQ_DATA_W-1:0] ld, rd, rt;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = in_value;
    end else begin : g_body
      assign lv = valid_w[i-1];
      assign ld = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv = 1'b0;
      assign rd = '0;
      assign rt = '0;
    end else begin : g_mid
      assign rv = valid_w[i+1];
      assign rd = data_w[i+1];
      assign rt = tail_w[i+1];
    end
    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .right_tail  (rt),
      .valid_o     (valid_w[i]),
      .data_o      (data_w[i]),
      .tail_o      (tail_w[i])
    );
  end

  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != S_IDLE) | ~slot_free;
  assign accept    = in_valid & ~in_stall;
  assign full      = valid_w[DEPTH-1];
  assign empty     = ~valid_w[0];
  assign cmd       = deq_cmd_t'(in_cmd);

  // Decode the command, drive the cells and form the result
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_ok_nxt     = out_ok_r;
    out_popped_nxt = out_popped_r;
    out_empty_nxt  = out_empty_r;
    ctl.en         = 1'b0;
    ctl.cmd        = cmd;
    ctl.value      = in_value;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              ctl.en         = ~full;
              out_valid_nxt  = 1'b1;
              out_ok_nxt     = ~full;
              out_popped_nxt = '0;
              out_empty_nxt  = 1'b0;
            end
            CMD_POP_FRONT: begin
              ctl.en         = ~empty;
              out_valid_nxt  = 1'b1;
              out_ok_nxt     = ~empty;
              out_popped_nxt = empty ? '0 : data_w[0];
              out_empty_nxt  = ~valid_w[1];
            end
            CMD_POP_BACK: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_ok_nxt     = 1'b0;
                out_popped_nxt = '0;
                out_empty_nxt  = 1'b1;
              end else begin
                // wait for the back entry to reach cell 0
                state_nxt = S_SETTLE;
                cnt_nxt   = CNT_W'(DEPTH - 1);
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SETTLE: begin
        ctl.cmd = CMD_POP_BACK;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (slot_free) begin
          ctl.en         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b1;
          out_popped_nxt = tail_w[0];
          out_empty_nxt  = ~valid_w[1];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ok_r     <= out_ok_nxt;
    out_popped_r <= out_popped_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_popped_value = out_popped_r;
  assign out_is_empty     = out_empty_r;

  // Live entries always form one run starting at cell 0
  a_packed_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_w + 1'b1) & valid_w) == '0)
    else $error("queue entries are not packed at the front");

  // The chain stays still while the back entry travels forward
  a_settle_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETTLE && cnt_r != '0) |=> $stable(valid_w))
    else $error("chain changed during pop back");

  // A failed command reports a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_popped_r == '0)
    else $error("failed command carries a value");

  // An accepted push into a queue with room leaves it non-empty
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
      |=> valid_w[0])
    else $error("push did not store an entry");

endmodule

### sv/deq_cell.sv
// One storage cell of the queue chain: an entry, its valid bit and a
// back-entry forwarding register. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell import deq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  deq_ctl_t                     ctl,
  input  logic                         left_valid,
  input  logic signed [DEQ_DATA_W-1:0] left_data,
  input  logic                         right_valid,
  input  logic signed [DEQ_DATA_W-1:0] right_data,
  input  logic signed [DEQ_DATA_W-1:0] right_tail,
  output logic                         valid_o,
  output logic signed [DEQ_DATA_W-1:0] data_o,
  output logic signed [DEQ_DATA_W-1:0] tail_o
);

  logic                         valid_r, valid_nxt;
  logic signed [DEQ_DATA_W-1:0] data_r, data_nxt;
  logic signed [DEQ_DATA_W-1:0] tail_r, tail_nxt;
  logic                         is_last;

  // This cell holds the back entry when the next cell is empty
  assign is_last = valid_r & ~right_valid;

  // Shift, fill or drop the entry as the command asks
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.en) begin
      unique case (ctl.cmd)
        CMD_PUSH_FRONT: begin
          valid_nxt = left_valid;
          data_nxt  = left_data;
        end
        CMD_PUSH_BACK: begin
          if (left_valid && !valid_r) begin
            valid_nxt = 1'b1;
            data_nxt  = ctl.value;
          end
        end
        CMD_POP_FRONT: begin
          valid_nxt = right_valid;
          data_nxt  = right_data;
        end
        CMD_POP_BACK: begin
          if (is_last) valid_nxt = 1'b0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // Forward the back entry one cell toward the front each cycle
  assign tail_nxt = is_last ? data_r : right_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    tail_r <= tail_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
  assign tail_o  = tail_r;

endmodule
